>>> rtl/core/vertex_rotate_project_triangle_macros.svh
// Assertion macros for the checker file of the vertex projection block.
`ifndef VERTEX_ROTATE_PROJECT_TRIANGLE_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_TRIANGLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define VRPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define VRPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/vrpt_pkg.sv
// Shared types, constants and trig table for the vertex projection block.
package vrpt_pkg;

  localparam int POS_W    = 16;
  localparam int TRIG_W   = 16;
  localparam int SCR_W    = 12;
  localparam int COLOR_W  = 8;
  localparam int ANGLE_W  = 16;
  localparam int DEG_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_BITS = 6 * SCR_W + COLOR_W;

  localparam int SCREEN_W_DEF = 128;
  localparam int SCREEN_H_DEF = 64;

  localparam int QUEUE_DEPTH = 2;

  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_3QUARTER = 270;
  // Reciprocal of 360 scaled by 2^22, rounded up; exact for magnitudes up to 32768.
  localparam int RECIP_360   = 11651;
  localparam int RECIP_SHIFT = 22;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd1;

  localparam logic signed [13:0] SAT_HI = 14'sd2047;
  localparam logic signed [13:0] SAT_LO = -14'sd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_X = 2'd0,
    CFG_ANGLE_Y = 2'd1,
    CFG_COLOR   = 2'd2
  } cfg_idx_t;

  // One classified vertex on its way from the front to the back.
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic                     emit;
    logic                     slot;
    logic [COLOR_W-1:0]       color;
  } vertex_item_t;

  // Q1.14 sine of 0..90 degrees.
  localparam logic [14:0] SIN_TAB [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine of a reduced angle in 0..359 degrees, by quadrant symmetry.
  function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] idx;
    logic             neg;
    begin
      if (d <= DEG_W'(DEG_QUARTER)) begin
        idx = d;
        neg = 1'b0;
      end else if (d <= DEG_W'(DEG_HALF)) begin
        idx = DEG_W'(DEG_HALF) - d;
        neg = 1'b0;
      end else if (d <= DEG_W'(DEG_3QUARTER)) begin
        idx = d - DEG_W'(DEG_HALF);
        neg = 1'b1;
      end else begin
        idx = DEG_W'(DEG_FULL) - d;
        neg = 1'b1;
      end
      sine_deg = neg ? -$signed({1'b0, SIN_TAB[idx[6:0]]})
                     : $signed({1'b0, SIN_TAB[idx[6:0]]});
    end
  endfunction

  function automatic logic signed [TRIG_W-1:0] cosine_deg(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] s;
    begin
      s = (d >= DEG_W'(DEG_3QUARTER)) ? d - DEG_W'(DEG_3QUARTER) : d + DEG_W'(DEG_QUARTER);
      cosine_deg = sine_deg(s);
    end
  endfunction

endpackage

>>> rtl/core/vrpt_if.sv
// Valid/ready channel interfaces for vertices in and triangles out.
interface vrpt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vrpt_pkg::POS_W-1:0]   pos_x;
  logic signed [vrpt_pkg::POS_W-1:0]   pos_y;
  logic signed [vrpt_pkg::POS_W-1:0]   pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface vrpt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vrpt_pkg::SCR_W-1:0]   corner1_x;
  logic signed [vrpt_pkg::SCR_W-1:0]   corner1_y;
  logic signed [vrpt_pkg::SCR_W-1:0]   corner2_x;
  logic signed [vrpt_pkg::SCR_W-1:0]   corner2_y;
  logic signed [vrpt_pkg::SCR_W-1:0]   corner3_x;
  logic signed [vrpt_pkg::SCR_W-1:0]   corner3_y;
  logic [vrpt_pkg::COLOR_W-1:0]        tri_color;

  modport source (output valid, output corner1_x, output corner1_y, output corner2_x,
                  output corner2_y, output corner3_x, output corner3_y,
                  output tri_color, input ready);
  modport sink   (input valid, input corner1_x, input corner1_y, input corner2_x,
                  input corner2_y, input corner3_x, input corner3_y,
                  input tri_color, output ready);
endinterface

>>> rtl/core/vrpt_front.sv
// Front end: configuration registers, vertex acceptance, phase tracking and trig lookup.
module vrpt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  vrpt_in_if.sink                             in_ch,
  input  logic                                cfg_we,
  input  logic [vrpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrpt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output vrpt_pkg::vertex_item_t              q_item
);
  import vrpt_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

  logic [DEG_W-1:0]   ang_x_r;
  logic [DEG_W-1:0]   ang_y_r;
  logic [COLOR_W-1:0] color_r;
  phase_t             phase_r;
  phase_t             phase_nxt;
  logic               slot;
  logic               emit;

  // C-style remainder by 360, folded into 0..359.
  function automatic logic [DEG_W-1:0] reduce_deg(input logic signed [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] mag;
    logic [29:0]        prod;
    logic [6:0]         q;
    logic [ANGLE_W-1:0] rem;
    logic [DEG_W-1:0]   r;
    begin
      mag  = a[ANGLE_W-1] ? ANGLE_W'(-a) : ANGLE_W'(a);
      prod = 30'(mag) * 30'(RECIP_360);
      q    = 7'(prod >> RECIP_SHIFT);
      rem  = mag - ANGLE_W'(ANGLE_W'(q) * ANGLE_W'(DEG_FULL));
      r    = rem[DEG_W-1:0];
      if (a[ANGLE_W-1] && (r != '0)) begin
        r = DEG_W'(DEG_FULL) - r;
      end
      reduce_deg = r;
    end
  endfunction

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    slot      = 1'b0;
    emit      = 1'b0;
    phase_nxt = PH_SECOND;
    unique case (phase_r)
      PH_FIRST: begin
        slot      = 1'b0;
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        slot      = 1'b1;
        phase_nxt = PH_THIRD;
      end
      PH_THIRD: begin
        emit      = 1'b1;
        phase_nxt = PH_FIRST;
      end
      default: begin
        slot      = 1'b0;
        phase_nxt = PH_SECOND;
      end
    endcase
  end

  always_comb begin
    q_item.pos_x = in_ch.pos_x;
    q_item.pos_y = in_ch.pos_y;
    q_item.pos_z = in_ch.pos_z;
    q_item.sin_x = sine_deg(ang_x_r);
    q_item.cos_x = cosine_deg(ang_x_r);
    q_item.sin_y = sine_deg(ang_y_r);
    q_item.cos_y = cosine_deg(ang_y_r);
    q_item.emit  = emit;
    q_item.slot  = slot;
    q_item.color = color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_x_r <= '0;
      ang_y_r <= '0;
      color_r <= COLOR_RESET;
      phase_r <= PH_FIRST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ANGLE_X: ang_x_r <= reduce_deg(cfg_data[ANGLE_W-1:0]);
          CFG_ANGLE_Y: ang_y_r <= reduce_deg(cfg_data[ANGLE_W-1:0]);
          CFG_COLOR:   color_r <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (q_push) begin
        phase_r <= phase_nxt;
      end
    end
  end

endmodule

>>> rtl/core/vrpt_fifo.sv
// Short queue of classified vertices between the front and the back.
module vrpt_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  vrpt_pkg::vertex_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output vrpt_pkg::vertex_item_t head
);
  import vrpt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vertex_item_t     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/vrpt_back.sv
// Back end: rotation and projection on one shared multiplier, corner hold and triangle output.
module vrpt_back #(
  parameter int SCREEN_WIDTH  = vrpt_pkg::SCREEN_W_DEF,
  parameter int SCREEN_HEIGHT = vrpt_pkg::SCREEN_H_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  vrpt_pkg::vertex_item_t q_head,
  output logic                   q_pop,
  vrpt_out_if.source             out_ch
);
  import vrpt_pkg::*;

  localparam logic signed [33:0] OFF_X = 34'(SCREEN_WIDTH / 2) << 20;
  localparam logic signed [47:0] OFF_Y = 48'(SCREEN_HEIGHT / 2) << 34;
  localparam logic [33:0]        RND_X = 34'hF_FFFF;
  localparam logic [47:0]        RND_Y = 48'h3_FFFF_FFFF;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CYX  = 9'b000000010,
    S_SYZ  = 9'b000000100,
    S_CYZ  = 9'b000001000,
    S_SYX  = 9'b000010000,
    S_CXY  = 9'b000100000,
    S_SXI  = 9'b001000000,
    S_ACC  = 9'b010000000,
    S_DONE = 9'b100000000
  } step_t;

  step_t              state_r;
  step_t              state_nxt;
  vertex_item_t       item_r;
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [48:0] prod_r;
  logic signed [33:0] px_r;
  logic signed [32:0] inner_r;
  logic signed [47:0] py_r;
  logic [33:0]        px_adj;
  logic [47:0]        py_adj;
  logic signed [SCR_W-1:0] scr_x;
  logic signed [SCR_W-1:0] scr_y;
  logic               stall;
  logic               finish;
  logic signed [SCR_W-1:0] hx_r [2];
  logic signed [SCR_W-1:0] hy_r [2];
  logic               out_valid_r;
  logic signed [SCR_W-1:0] c1x_r, c1y_r, c2x_r, c2y_r, c3x_r, c3y_r;
  logic [COLOR_W-1:0] color_r;

  function automatic logic signed [SCR_W-1:0] sat12(input logic signed [13:0] q);
    if (q > SAT_HI) begin
      sat12 = SCR_W'(SAT_HI);
    end else if (q < SAT_LO) begin
      sat12 = SCR_W'(SAT_LO);
    end else begin
      sat12 = SCR_W'(q);
    end
  endfunction

  // A triangle cannot leave while the previous one still waits at the output.
  assign stall  = (state_r == S_DONE) && item_r.emit && out_valid_r && !out_ch.ready;
  assign finish = (state_r == S_DONE) && !stall;
  assign q_pop  = q_valid && ((state_r == S_IDLE) || finish);

  always_comb begin
    mul_a = item_r.cos_y;
    mul_b = {{17{item_r.pos_x[15]}}, item_r.pos_x};
    case (state_r)
      S_CYX: begin
        mul_a = item_r.cos_y;
        mul_b = {{17{item_r.pos_x[15]}}, item_r.pos_x};
      end
      S_SYZ: begin
        mul_a = item_r.sin_y;
        mul_b = {{17{item_r.pos_z[15]}}, item_r.pos_z};
      end
      S_CYZ: begin
        mul_a = item_r.cos_y;
        mul_b = {{17{item_r.pos_z[15]}}, item_r.pos_z};
      end
      S_SYX: begin
        mul_a = item_r.sin_y;
        mul_b = {{17{item_r.pos_x[15]}}, item_r.pos_x};
      end
      S_CXY: begin
        mul_a = item_r.cos_x;
        mul_b = {{17{item_r.pos_y[15]}}, item_r.pos_y};
      end
      S_SXI: begin
        mul_a = item_r.sin_x;
        mul_b = inner_r;
      end
      default: ;
    endcase
  end

  // Truncation toward zero: negative values are biased up before the arithmetic shift.
  always_comb begin
    px_adj = px_r + (px_r[33] ? RND_X : 34'd0);
    py_adj = py_r + (py_r[47] ? RND_Y : 48'd0);
    scr_x  = sat12($signed(px_adj[33:20]));
    scr_y  = sat12($signed(py_adj[47:34]));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: state_nxt = q_valid ? S_CYX : S_IDLE;
      S_CYX:  state_nxt = S_SYZ;
      S_SYZ:  state_nxt = S_CYZ;
      S_CYZ:  state_nxt = S_SYX;
      S_SYX:  state_nxt = S_CXY;
      S_CXY:  state_nxt = S_SXI;
      S_SXI:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_DONE;
      S_DONE: begin
        if (stall) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = q_valid ? S_CYX : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (finish && item_r.emit) || (out_valid_r && !out_ch.ready);
    end
  end

  // Each state folds in the product that prod_r registered during the state before it.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (q_pop) begin
      item_r <= q_head;
    end
    case (state_r)
      S_SYZ: px_r    <= prod_r[33:0] + OFF_X;
      S_CYZ: px_r    <= px_r + prod_r[33:0];
      S_SYX: inner_r <= prod_r[32:0];
      S_CXY: inner_r <= inner_r - prod_r[32:0];
      S_SXI: py_r    <= $signed({prod_r[33:0], 14'd0}) + OFF_Y;
      S_ACC: py_r    <= py_r + prod_r[47:0];
      default: ;
    endcase
    if (finish && !item_r.emit) begin
      hx_r[item_r.slot] <= scr_x;
      hy_r[item_r.slot] <= scr_y;
    end
    if (finish && item_r.emit) begin
      c1x_r   <= hx_r[0];
      c1y_r   <= hy_r[0];
      c2x_r   <= hx_r[1];
      c2y_r   <= hy_r[1];
      c3x_r   <= scr_x;
      c3y_r   <= scr_y;
      color_r <= item_r.color;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.corner1_x = c1x_r;
  assign out_ch.corner1_y = c1y_r;
  assign out_ch.corner2_x = c2x_r;
  assign out_ch.corner2_y = c2y_r;
  assign out_ch.corner3_x = c3x_r;
  assign out_ch.corner3_y = c3y_r;
  assign out_ch.tri_color = color_r;

endmodule

>>> rtl/core/vertex_rotate_project_triangle.sv
// Top level of the vertex rotation, projection and triangle assembly block.
// Vertices enter on in_ch; every third accepted vertex yields one triangle on out_ch carrying
// the three projected corners in arrival order and the draw color current at the third vertex.
// The back end computes six dependent products on a single shared 16x33 multiplier, so it
// works on one vertex at a time and takes the next vertex from the queue only as the last one
// finishes; a triangle's corners pass through the queue, the back end's steps and the output
// register before it is presented on out_ch. A two-entry queue lets the front keep accepting
// while the back is busy, and the output register lets the back continue while a triangle
// waits to be taken, until the next triangle is ready to leave. Angles written on the cfg port
// are reduced modulo 360 as they are written; write configuration only while the block is idle.
module vertex_rotate_project_triangle #(
  parameter int SCREEN_WIDTH  = vrpt_pkg::SCREEN_W_DEF,
  parameter int SCREEN_HEIGHT = vrpt_pkg::SCREEN_H_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  vrpt_in_if.sink                         in_ch,
  vrpt_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [vrpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vrpt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vrpt_pkg::*;

  vertex_item_t push_item;
  vertex_item_t head_item;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;

  vrpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  vrpt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_item)
  );

  vrpt_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (head_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/core/vrpt_checker.sv
// Port-level checker for the vertex projection block, bound to its top level.
`include "vertex_rotate_project_triangle_macros.svh"

module vrpt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [vrpt_pkg::OUT_BITS-1:0]   out_data
);
  import vrpt_pkg::*;

  logic [1:0] trip_r;
  logic [2:0] owed_r;
  logic       in_xfer;
  logic       out_xfer;
  logic       owe_inc;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign owe_inc  = in_xfer && (trip_r == 2'd2);

  // Triangles whose third vertex has been taken but that have not yet been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_r <= '0;
      owed_r <= '0;
    end else begin
      if (in_xfer) begin
        trip_r <= (trip_r == 2'd2) ? 2'd0 : trip_r + 2'd1;
      end
      owed_r <= owed_r + {2'd0, owe_inc} - {2'd0, out_xfer};
    end
  end

  `VRPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "out valid dropped while stalled")
  `VRPT_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "out payload changed while stalled")
  `VRPT_ASSERT_IMP(a_out_earned, out_xfer, owed_r != 3'd0, "triangle delivered without three vertices")
  `VRPT_ASSERT_IMP(a_owed_cap, 1'b1, owed_r <= 3'd2, "more triangles in flight than the block can hold")

endmodule

bind vertex_rotate_project_triangle vrpt_checker u_vrpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.corner1_x, out_ch.corner1_y, out_ch.corner2_x, out_ch.corner2_y,
               out_ch.corner3_x, out_ch.corner3_y, out_ch.tri_color})
);

>>> bench/vertex_rotate_project_triangle_tb.sv
// Self-checking testbench for the vertex rotation, projection and triangle assembly block.
`timescale 1ns / 100ps

module vertex_rotate_project_triangle_tb;
  import vrpt_pkg::*;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int DRAIN_CYCLES  = 48;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 10;

  typedef struct packed {
    logic signed [SCR_W-1:0] corner1_x;
    logic signed [SCR_W-1:0] corner1_y;
    logic signed [SCR_W-1:0] corner2_x;
    logic signed [SCR_W-1:0] corner2_y;
    logic signed [SCR_W-1:0] corner3_x;
    logic signed [SCR_W-1:0] corner3_y;
    logic [COLOR_W-1:0]      tri_color;
  } triangle_t;

  class triangle_scoreboard;
    int                        errors;
    int                        sine_q14 [91];
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic [COLOR_W-1:0]        color;
    int                        corners_held;
    logic signed [SCR_W-1:0]   held_x [2];
    logic signed [SCR_W-1:0]   held_y [2];
    triangle_t                 expected_triangles [$];

    function new();
      for (int d = 0; d <= 90; d++)
        sine_q14[d] = $rtoi(16384.0 * $sin(d * 3.141592653589793 / 180.0) + 0.5);
      errors = 0;
      angle_x = 0;
      angle_y = 0;
      color = 8'd1;
      corners_held = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_ANGLE_X: angle_x = value;
        CFG_ANGLE_Y: angle_y = value;
        CFG_COLOR:   color = value[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Degree argument in 0..359; the table covers one quadrant.
    function longint sine_of(int deg);
      if (deg <= 90) return sine_q14[deg];
      if (deg <= 180) return sine_q14[180 - deg];
      if (deg <= 270) return -sine_q14[deg - 180];
      return -sine_q14[360 - deg];
    endfunction

    function int reduce(logic signed [ANGLE_W-1:0] a);
      int r;
      r = int'(a) % 360;
      return (r < 0) ? r + 360 : r;
    endfunction

    // Truncates toward zero, then clamps to the 12-bit screen range.
    function logic signed [SCR_W-1:0] to_screen(longint v, int sh);
      longint q;
      q = (v < 0) ? -((-v) >>> sh) : (v >>> sh);
      if (q > 2047) q = 2047;
      if (q < -2048) q = -2048;
      return q[SCR_W-1:0];
    endfunction

    function void note_vertex(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                              logic signed [POS_W-1:0] pz);
      longint x, y, z, sy, cy, sx, cx, sum_x, sum_y;
      int ax, ay;
      logic signed [SCR_W-1:0] scr_x, scr_y;
      triangle_t t;
      x = px;
      y = py;
      z = pz;
      ay = reduce(angle_y);
      ax = reduce(angle_x);
      sy = sine_of(ay);
      cy = sine_of((ay + 90) % 360);
      sx = sine_of(ax);
      cx = sine_of((ax + 90) % 360);
      // Screen x is kept in Q20 and screen y in Q34 until the final truncation.
      sum_x = cy * x + sy * z + (longint'(SCREEN_WIDTH / 2) <<< 20);
      sum_y = cx * y * 16384 + sx * (cy * z - sy * x) + (longint'(SCREEN_HEIGHT / 2) <<< 34);
      scr_x = to_screen(sum_x, 20);
      scr_y = to_screen(sum_y, 34);
      if (corners_held < 2) begin
        held_x[corners_held] = scr_x;
        held_y[corners_held] = scr_y;
        corners_held++;
      end else begin
        t.corner1_x = held_x[0];
        t.corner1_y = held_y[0];
        t.corner2_x = held_x[1];
        t.corner2_y = held_y[1];
        t.corner3_x = scr_x;
        t.corner3_y = scr_y;
        t.tri_color = color;
        expected_triangles.push_back(t);
        corners_held = 0;
      end
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_triangle(triangle_t got);
      triangle_t want;
      if (expected_triangles.size() == 0) begin
        errors++;
        $display("%0t: triangle with none expected, actual (%0d,%0d) (%0d,%0d) (%0d,%0d) color %0d",
                 $time, got.corner1_x, got.corner1_y, got.corner2_x, got.corner2_y,
                 got.corner3_x, got.corner3_y, got.tri_color);
        return;
      end
      want = expected_triangles.pop_front();
      compare("corner1_x", want.corner1_x, got.corner1_x);
      compare("corner1_y", want.corner1_y, got.corner1_y);
      compare("corner2_x", want.corner2_x, got.corner2_x);
      compare("corner2_y", want.corner2_y, got.corner2_y);
      compare("corner3_x", want.corner3_x, got.corner3_x);
      compare("corner3_y", want.corner3_y, got.corner3_y);
      compare("tri_color", want.tri_color, got.tri_color);
    endfunction

    function int pending();
      return expected_triangles.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vrpt_in_if  in_ch ();
  vrpt_out_if out_ch ();

  vertex_rotate_project_triangle #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  triangle_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_triangle({out_ch.corner1_x, out_ch.corner1_y, out_ch.corner2_x,
                         out_ch.corner2_y, out_ch.corner3_x, out_ch.corner3_y,
                         out_ch.tri_color});
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("vertex_rotate_project_triangle verification failed");
    $finish;
  end

  // Offers one vertex and returns at the edge where the transaction completes.
  task automatic push_vertex(input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    in_ch.pos_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_vertex(x, y, z);
  endtask

  // Vertices that complete no triangle may still be in flight, hence the extra cycles.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_config(input logic signed [ANGLE_W-1:0] ax,
                                input logic signed [ANGLE_W-1:0] ay,
                                input logic [COLOR_W-1:0] color);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ANGLE_X;
    cfg_data  <= ax;
    @(posedge clk);
    cfg_index <= CFG_ANGLE_Y;
    cfg_data  <= ay;
    @(posedge clk);
    cfg_index <= CFG_COLOR;
    cfg_data  <= {{(CFG_DATA_W - COLOR_W){1'b0}}, color};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_ANGLE_X, ax);
    sb.set_reg(CFG_ANGLE_Y, ay);
    sb.set_reg(CFG_COLOR, {{(CFG_DATA_W - COLOR_W){1'b0}}, color});
  endtask

  function automatic logic signed [POS_W-1:0] random_coord();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1, 2: return POS_W'($urandom_range(511) - 256);
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    case ($urandom_range(3))
      0: return ANGLE_W'(($urandom_range(16) - 8) * 90);
      1: return ANGLE_W'($urandom_range(720) - 360);
      default: return ANGLE_W'($urandom());
    endcase
  endfunction

  initial begin
    sb = new();
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_ANGLE_X;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.pos_z <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: no rotation, color 1.
    push_vertex(16'sh0000, 16'sh0000, 16'sh0000);
    push_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_vertex(16'sh8000, 16'sh8000, 16'sh8000);
    push_vertex(16'sh7fff, 16'sh8000, 16'sh0000);
    push_vertex(16'sh8000, 16'sh7fff, -16'sd1);
    push_vertex(16'sd1, -16'sd1, 16'sh7fff);

    program_config(16'sd90, 16'sd270, 8'd255);
    push_vertex(16'sh7fff, 16'sh8000, 16'sh7fff);
    push_vertex(16'sh8000, 16'sh7fff, 16'sh8000);
    push_vertex(16'sd64, -16'sd64, 16'sd128);

    // Extreme angles exercise the remainder with negative operands.
    program_config(16'sh7fff, 16'sh8000, 8'd0);
    push_vertex(16'sh7fff, 16'sh7fff, 16'sh8000);
    push_vertex(16'sh8000, 16'sh8000, 16'sh7fff);
    push_vertex(16'sh0000, 16'sh7fff, 16'sh8000);

    program_config(-16'sd1, 16'sd180, 8'h55);
    push_vertex(16'sh7fff, 16'sh0000, 16'sh7fff);
    push_vertex(16'sh8000, 16'sh0000, 16'sh8000);
    push_vertex(16'sh1234, -16'sh4321, 16'sh0abc);

    // The color changes after the first corner; the third corner's color must win.
    program_config(16'sd360, -16'sd360, 8'haa);
    push_vertex(16'sd640, 16'sd320, -16'sd640);
    program_config(16'sd360, -16'sd360, 8'h0f);
    push_vertex(-16'sd640, 16'sd320, 16'sd640);
    push_vertex(16'sd0, -16'sd320, 16'sd0);

    for (int p = 0; p < PHASES; p++) begin
      int count;
      if (p < 4) begin
        send_idle_pct = 28;
        recv_idle_pct = 85;
      end else if (p < 7) begin
        send_idle_pct = 85;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_config(random_angle(), random_angle(), COLOR_W'($urandom_range(255)));
      // Long receiver hold-off while the sender keeps offering, so the block backs up.
      if (p == 2) hold_request = 1'b1;
      count = $urandom_range(60, 80);
      for (int i = 0; i < count; i++) begin
        if (p == 5 && i == count / 2) drain();
        push_vertex(random_coord(), random_coord(), random_coord());
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("vertex_rotate_project_triangle verification clean");
    else
      $display("vertex_rotate_project_triangle verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/vrpt_pkg.sv
rtl/core/vrpt_if.sv
rtl/core/vrpt_front.sv
rtl/core/vrpt_fifo.sv
rtl/core/vrpt_back.sv
rtl/core/vertex_rotate_project_triangle.sv
rtl/core/vrpt_checker.sv
bench/vertex_rotate_project_triangle_tb.sv
